/* rtl/core/chained_hash_table_top_defines.svh */
// ----------------------------------------------------------------------------
// Chained hash table assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef CHAINED_HASH_TABLE_TOP_DEFINES_SVH
`define CHAINED_HASH_TABLE_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CHT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("chained hash table check failed");

// Consequent must hold in the cycle after the antecedent.
`define CHT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("chained hash table check failed");

`endif

/* rtl/core/cht_pkg.sv */
// ----------------------------------------------------------------------------
// Chained hash table package
// Sizes, codes and the structs passed between the top level and the core.
// ----------------------------------------------------------------------------
`default_nettype none

package cht_pkg;

  localparam int BUCKETS   = 10;
  localparam int POOL      = 64;
  localparam int KEY_W     = 32;
  localparam int SLOT_W    = 6;

  // Node pointers carry one extra code, POOL, for the end of a chain.
  localparam int PTR_W     = $clog2(POOL + 1);
  localparam int IDX_W     = $clog2(POOL);
  localparam int STEP_W    = $clog2(POOL + 1);
  localparam int BKT_W     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam logic [PTR_W-1:0] NIL = PTR_W'(POOL);

  // Modulo unit: key bits folded in per cycle.
  localparam int HASH_BITS = 8;
  localparam int HASH_CYC  = KEY_W / HASH_BITS;
  localparam int HCNT_W    = (HASH_CYC > 1) ? $clog2(HASH_CYC) : 1;
  localparam int HASH_R    = BKT_W + 1;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_SEARCH = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_POOL_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_HEAD,
    S_INS_FREE,
    S_INS_WALK,
    S_WALK,
    S_DEL_FREE,
    S_RESP
  } state_t;

  typedef struct packed {
    logic             valid;
    cmd_t             cmd;
    logic [KEY_W-1:0] key;
  } req_t;

  typedef struct packed {
    logic              valid;
    status_t           status;
    logic [SLOT_W-1:0] slot;
  } res_t;

endpackage

`default_nettype wire

/* rtl/core/cht_ram.sv */
// ----------------------------------------------------------------------------
// Chained hash table RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/core/cht_hash.sv */
// ----------------------------------------------------------------------------
// Chained hash table bucket hash
// Key modulo BUCKETS, folded MSB first a byte per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cht_hash import cht_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [KEY_W-1:0] key,
  output logic             done,
  output logic [BKT_W-1:0] bucket
);

  logic [KEY_W-1:0]  sh;
  logic [HASH_R-1:0] rem;
  logic [HASH_R-1:0] rem_next;
  logic [HCNT_W-1:0] cnt;
  logic              run;

  // Remainder stays below BUCKETS, so one conditional subtract per bit.
  always_comb begin
    rem_next = rem;
    for (int i = 0; i < HASH_BITS; i++) begin
      rem_next = {rem_next[HASH_R-2:0], sh[KEY_W-1-i]};
      if (rem_next >= HASH_R'(BUCKETS)) begin
        rem_next = rem_next - HASH_R'(BUCKETS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && cnt == '0) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= key;
      rem <= '0;
      cnt <= HCNT_W'(HASH_CYC - 1);
    end else if (run) begin
      sh  <= sh << HASH_BITS;
      rem <= rem_next;
      cnt <= cnt - 1'b1;
    end
  end

  assign bucket = rem[BKT_W-1:0];

endmodule

`default_nettype wire

/* rtl/core/cht_core.sv */
// ----------------------------------------------------------------------------
// Chained hash table core
// Sequencer over the bucket head, node key and node link memories.
// ----------------------------------------------------------------------------
`default_nettype none

module cht_core import cht_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  req_t req,
  output logic ready,
  output res_t res,
  input  logic res_ready
);

  state_t state, state_next;

  logic             hash_start;
  logic             hash_done;
  logic [BKT_W-1:0] hash_bucket;

  cmd_t              cmd_q;
  logic [KEY_W-1:0]  key_q;
  logic [BKT_W-1:0]  b_q;
  logic [PTR_W-1:0]  cur;
  logic [PTR_W-1:0]  prev;
  logic [PTR_W-1:0]  n_q;
  logic [STEP_W-1:0] steps;
  logic [PTR_W-1:0]  free_head;
  status_t           res_status;
  logic [SLOT_W-1:0] res_slot;

  logic             head_we;
  logic [BKT_W-1:0] head_wa;
  logic [PTR_W-1:0] head_wd;
  logic [BKT_W-1:0] head_ra;
  logic [PTR_W-1:0] head_rd;
  logic             head_vld [BUCKETS];
  logic             head_vld_q;

  logic             key_we;
  logic [IDX_W-1:0] key_wa;
  logic [KEY_W-1:0] key_wd;
  logic [IDX_W-1:0] key_ra;
  logic [KEY_W-1:0] key_rd;

  logic             link_we;
  logic [IDX_W-1:0] link_wa;
  logic [PTR_W-1:0] link_wd;
  logic [IDX_W-1:0] link_ra;
  logic [PTR_W-1:0] link_rd;
  logic             link_vld [POOL];
  logic             link_vld_q;
  logic [IDX_W-1:0] link_ra_q;

  logic [PTR_W-1:0] head_val;
  logic [PTR_W-1:0] link_val;
  logic             pool_full;
  logic             head_nil;
  logic             key_hit;
  logic             link_end;
  logic             last_step;
  logic             ins_more;

  cht_hash u_hash (
    .clk    (clk),
    .rst    (rst),
    .start  (hash_start),
    .key    (req.key),
    .done   (hash_done),
    .bucket (hash_bucket)
  );

  cht_ram #(.WIDTH(PTR_W), .DEPTH(BUCKETS), .AW(BKT_W)) u_head_ram (
    .clk   (clk),
    .we    (head_we),
    .waddr (head_wa),
    .wdata (head_wd),
    .raddr (head_ra),
    .rdata (head_rd)
  );

  cht_ram #(.WIDTH(KEY_W), .DEPTH(POOL), .AW(IDX_W)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_wa),
    .wdata (key_wd),
    .raddr (key_ra),
    .rdata (key_rd)
  );

  cht_ram #(.WIDTH(PTR_W), .DEPTH(POOL), .AW(IDX_W)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_wa),
    .wdata (link_wd),
    .raddr (link_ra),
    .rdata (link_rd)
  );

  // Unwritten entries read as their reset values: empty bucket, next free node.
  always_comb begin
    head_val  = head_vld_q ? head_rd : NIL;
    link_val  = link_vld_q ? link_rd : (PTR_W'(link_ra_q) + 1'b1);
    pool_full = (free_head >= NIL);
    head_nil  = (head_val >= NIL);
    key_hit   = (key_rd == key_q);
    link_end  = (link_val >= NIL);
    last_step = (steps == STEP_W'(POOL - 1));
    ins_more  = !link_end && (steps != STEP_W'(POOL));
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          if (req.cmd inside {CMD_INSERT, CMD_DELETE, CMD_SEARCH}) begin
            state_next = S_HASH;
          end else begin
            state_next = S_RESP;
          end
        end
      end
      S_HASH: begin
        if (hash_done) begin
          state_next = S_HEAD;
        end
      end
      S_HEAD: begin
        case (cmd_q)
          CMD_INSERT: state_next = pool_full ? S_RESP : S_INS_FREE;
          CMD_DELETE,
          CMD_SEARCH: state_next = head_nil ? S_RESP : S_WALK;
          default:    state_next = S_RESP;
        endcase
      end
      S_INS_FREE: state_next = (cur >= NIL) ? S_RESP : S_INS_WALK;
      S_INS_WALK: state_next = ins_more ? S_INS_WALK : S_RESP;
      S_WALK: begin
        if (key_hit) begin
          state_next = (cmd_q == CMD_DELETE) ? S_DEL_FREE : S_RESP;
        end else if (link_end || last_step) begin
          state_next = S_RESP;
        end
      end
      S_DEL_FREE: state_next = S_RESP;
      S_RESP: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ready      = 1'b0;
    hash_start = 1'b0;
    res.valid  = 1'b0;
    res.status = res_status;
    res.slot   = res_slot;
    head_we    = 1'b0;
    head_wa    = b_q;
    head_wd    = n_q;
    head_ra    = hash_bucket;
    key_we     = 1'b0;
    key_wa     = free_head[IDX_W-1:0];
    key_wd     = key_q;
    key_ra     = link_val[IDX_W-1:0];
    link_we    = 1'b0;
    link_wa    = n_q[IDX_W-1:0];
    link_wd    = NIL;
    link_ra    = link_val[IDX_W-1:0];
    case (state)
      S_IDLE: begin
        ready      = 1'b1;
        hash_start = req.valid;
      end
      S_HEAD: begin
        if (cmd_q == CMD_INSERT) begin
          link_ra = free_head[IDX_W-1:0];
          key_we  = !pool_full;
        end else begin
          key_ra  = head_val[IDX_W-1:0];
          link_ra = head_val[IDX_W-1:0];
        end
      end
      S_INS_FREE: begin
        link_we = 1'b1;
        link_ra = cur[IDX_W-1:0];
        head_we = (cur >= NIL);
      end
      S_INS_WALK: begin
        if (!ins_more) begin
          link_we = 1'b1;
          link_wa = cur[IDX_W-1:0];
          link_wd = n_q;
        end
      end
      S_WALK: begin
        if (key_hit && cmd_q == CMD_DELETE) begin
          head_wd = link_val;
          link_wd = link_val;
          link_wa = prev[IDX_W-1:0];
          if (prev >= NIL) begin
            head_we = 1'b1;
          end else begin
            link_we = 1'b1;
          end
        end
      end
      S_DEL_FREE: begin
        link_we = 1'b1;
        link_wa = cur[IDX_W-1:0];
        link_wd = free_head;
      end
      S_RESP: begin
        res.valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      free_head <= '0;
      for (int i = 0; i < BUCKETS; i++) begin
        head_vld[i] <= 1'b0;
      end
      for (int i = 0; i < POOL; i++) begin
        link_vld[i] <= 1'b0;
      end
    end else begin
      state <= state_next;
      if (head_we) begin
        head_vld[head_wa] <= 1'b1;
      end
      if (link_we) begin
        link_vld[link_wa] <= 1'b1;
      end
      if (state == S_INS_FREE) begin
        free_head <= link_val;
      end else if (state == S_DEL_FREE) begin
        free_head <= cur;
      end
    end
  end

  // Valid flags are registered alongside the RAM read, as the data is.
  always_ff @(posedge clk) begin
    head_vld_q <= head_vld[head_ra];
    link_vld_q <= link_vld[link_ra];
    link_ra_q  <= link_ra;
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          cmd_q      <= req.cmd;
          key_q      <= req.key;
          res_status <= ST_NOT_FOUND;
          res_slot   <= '0;
        end
      end
      S_HASH: begin
        if (hash_done) begin
          b_q <= hash_bucket;
        end
      end
      S_HEAD: begin
        cur   <= head_val;
        prev  <= NIL;
        steps <= '0;
        n_q   <= free_head;
        if (cmd_q == CMD_INSERT && pool_full) begin
          res_status <= ST_POOL_FULL;
        end
      end
      S_INS_FREE: begin
        res_status <= ST_DONE;
        res_slot   <= SLOT_W'(n_q);
      end
      S_INS_WALK: begin
        if (ins_more) begin
          cur   <= link_val;
          steps <= steps + 1'b1;
        end
      end
      S_WALK: begin
        if (key_hit) begin
          res_status <= ST_DONE;
          res_slot   <= SLOT_W'(cur);
        end else begin
          prev  <= cur;
          cur   <= link_val;
          steps <= steps + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/chained_hash_table_top.sv */
// ----------------------------------------------------------------------------
// Chained hash table
// Separate-chaining hash table over a fixed node pool with a free list.
// ----------------------------------------------------------------------------
//
//   channel   direction  tdata                tuser
//   s_axis    in         key [31:0]           cmd [1:0]
//   m_axis    out        slot [5:0], pad 0    status [1:0]
//
// One item is in work at a time. An item passes through the accept, the
// byte-serial modulo (four bytes and the done flag), the bucket head read, a
// walk over the chain nodes (at most the pool, 64) through the link and key
// memories with a free-list update on an insert or a hit delete, and the
// handover of the result; an unused command goes from the accept straight to
// the handover, and an insert on a full pool skips the walk and the update.
// Reset is synchronous; valid flags stand in for the reset contents of the head
// and link memories, so no clearing pass runs.
// The result waits in an output register, so the next item is taken while
// it is unread; a second result stalls the core until the first one leaves.
//
`default_nettype none

`include "chained_hash_table_top_defines.svh"

module chained_hash_table_top import cht_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // key [31:0]
  input  logic [1:0]  s_tuser,   // cmd [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // slot [5:0], zero [7:6]
  output logic [1:0]  m_tuser    // status [1:0]
);

  req_t req;
  res_t res;
  logic res_ready;

  // Decode the incoming item.
  always_comb begin
    req.valid = s_tvalid;
    req.cmd   = cmd_t'(s_tuser);
    req.key   = s_tdata;
  end

  // Output register is free when empty or being drained this cycle.
  assign res_ready = !m_tvalid || m_tready;

  cht_core u_core (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .ready     (s_tready),
    .res       (res),
    .res_ready (res_ready)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Hold the payload until the item is taken.
  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      m_tdata <= 8'(res.slot);
      m_tuser <= res.status;
    end
  end

  // One item at a time: the core is busy right after an accept.
  `CHT_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)
  // A result handed over always lands in the output register.
  `CHT_ASSERT_NEXT(a_result_lands, res.valid && res_ready, m_tvalid)
  // A failed command reports slot zero.
  `CHT_ASSERT_SAME(a_fail_slot_zero, m_tvalid && (m_tuser != ST_DONE), m_tdata == 8'd0)

endmodule

`default_nettype wire
